// ----- rtl/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: status codes, opcodes and the
// result word type shared by the parser and the top level.
// Depends on nothing.
package wsd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 64;
   localparam int unsigned KeyWidth    = 32;
   localparam int unsigned IndexWidth  = 4;

   localparam logic [6:0] LenCode16 = 7'd126;
   localparam logic [6:0] LenCode64 = 7'd127;

   typedef enum logic [3:0] {
      OP_CONT   = 4'h0,
      OP_TEXT   = 4'h1,
      OP_BINARY = 4'h2,
      OP_CLOSE  = 4'h8,
      OP_PING   = 4'h9,
      OP_PONG   = 4'hA
   } opcode_type;

   typedef enum logic [3:0] {
      ST_DATA       = 4'd0,
      ST_SHORT      = 4'd1,
      ST_NO_EXTLEN  = 4'd2,
      ST_NO_KEY     = 4'd3,
      ST_INCOMPLETE = 4'd4,
      ST_CLOSE      = 4'd5,
      ST_PING       = 4'd6,
      ST_PONG       = 4'd7,
      ST_UNKNOWN    = 4'd8
   } status_type;

   typedef struct packed {
      logic                   emit;
      logic [ByteWidth-1:0]   out_byte;
      logic                   byte_valid;
      logic                   frame_done;
      status_type             status;
      logic [3:0]             frame_opcode;
      logic [LengthWidth-1:0] payload_length;
   } result_type;

endpackage

// ----- rtl/wsd_parser.sv -----
// Header parser and payload unmasking state for the WebSocket deframer.
// Holds the per-frame state and forms the result for the current word.
// Depends on wsd_pkg.
module wsd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  logic                   frame_end,
   output wsd_pkg::result_type    result
);
   import wsd_pkg::*;

   logic [IndexWidth-1:0]  header_index_ff, header_index_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_flag_ff, mask_flag_in;
   logic [6:0]             length_code_ff, length_code_in;
   logic [LengthWidth-1:0] length_value_ff, length_value_in;
   logic [KeyWidth-1:0]    mask_key_ff, mask_key_in;
   logic [LengthWidth-1:0] payload_count_ff, payload_count_in;

   logic [IndexWidth-1:0]  ext_cur, hdr_cur, ext_new, hdr_new;
   logic                   data_op;
   logic                   valid;
   logic [ByteWidth-1:0]   key_byte;
   logic [ByteWidth-1:0]   ob;
   status_type             status;

   function automatic logic [IndexWidth-1:0] ext_bytes(input logic [6:0] code);
      logic [IndexWidth-1:0] n;
      n = '0;
      if (code == LenCode16) n = IndexWidth'(2);
      else if (code == LenCode64) n = IndexWidth'(8);
      return n;
   endfunction

   always_comb begin
      unique case (payload_count_ff[1:0])
         2'd0: key_byte = mask_key_ff[31:24];
         2'd1: key_byte = mask_key_ff[23:16];
         2'd2: key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      ext_cur = ext_bytes(length_code_ff);
      hdr_cur = IndexWidth'(2) + ext_cur + (mask_flag_ff ? IndexWidth'(4) : '0);
      data_op = (opcode_ff == OP_TEXT) || (opcode_ff == OP_BINARY);

      header_index_in  = header_index_ff;
      opcode_in        = opcode_ff;
      mask_flag_in     = mask_flag_ff;
      length_code_in   = length_code_ff;
      length_value_in  = length_value_ff;
      mask_key_in      = mask_key_ff;
      payload_count_in = payload_count_ff;
      valid            = 1'b0;
      ob               = in_byte ^ (mask_flag_ff ? key_byte : '0);

      priority if (header_index_ff == '0) begin
         opcode_in       = in_byte[3:0];
         header_index_in = IndexWidth'(1);
      end else if (header_index_ff == IndexWidth'(1)) begin
         mask_flag_in    = in_byte[7];
         length_code_in  = in_byte[6:0];
         length_value_in = (in_byte[6:0] < LenCode16) ? LengthWidth'(in_byte[6:0]) : '0;
         header_index_in = IndexWidth'(2);
      end else if (header_index_ff < IndexWidth'(2) + ext_cur) begin
         length_value_in = {length_value_ff[LengthWidth-9:0], in_byte};
         header_index_in = header_index_ff + IndexWidth'(1);
      end else if (header_index_ff < hdr_cur) begin
         mask_key_in     = {mask_key_ff[KeyWidth-9:0], in_byte};
         header_index_in = header_index_ff + IndexWidth'(1);
      end else if (payload_count_ff < length_value_ff) begin
         valid            = data_op;
         payload_count_in = payload_count_ff + LengthWidth'(1);
      end else begin
         valid = 1'b0;
      end

      ext_new = ext_bytes(length_code_in);
      hdr_new = IndexWidth'(2) + ext_new + (mask_flag_in ? IndexWidth'(4) : '0);
      priority if (header_index_in < IndexWidth'(2)) status = ST_SHORT;
      else if (header_index_in < IndexWidth'(2) + ext_new) status = ST_NO_EXTLEN;
      else if (header_index_in < hdr_new) status = ST_NO_KEY;
      else if (payload_count_in < length_value_in) status = ST_INCOMPLETE;
      else if ((opcode_in == OP_TEXT) || (opcode_in == OP_BINARY)) status = ST_DATA;
      else if (opcode_in == OP_CLOSE) status = ST_CLOSE;
      else if (opcode_in == OP_PING) status = ST_PING;
      else if (opcode_in == OP_PONG) status = ST_PONG;
      else status = ST_UNKNOWN;

      result.emit         = valid || frame_end;
      result.out_byte     = valid ? ob : '0;
      result.byte_valid   = valid;
      result.frame_done   = frame_end;
      result.frame_opcode = opcode_in;
      result.status       = frame_end ? status : ST_DATA;
      result.payload_length = (frame_end && (status != ST_SHORT) && (status != ST_NO_EXTLEN))
                              ? length_value_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         header_index_ff  <= '0;
         opcode_ff        <= '0;
         mask_flag_ff     <= 1'b0;
         length_code_ff   <= '0;
         length_value_ff  <= '0;
         mask_key_ff      <= '0;
         payload_count_ff <= '0;
      end else if (step) begin
         header_index_ff  <= header_index_in;
         opcode_ff        <= opcode_in;
         mask_flag_ff     <= mask_flag_in;
         length_code_ff   <= length_code_in;
         length_value_ff  <= length_value_in;
         mask_key_ff      <= mask_key_in;
         payload_count_ff <= payload_count_in;
      end
   end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: stream handshake and result
// register around the header parser. Depends on wsd_pkg and wsd_parser.
//
// The req channel takes one raw frame byte per word in req_tdata, with
// req_tlast high on the last byte of the frame buffer. The rsp channel gives
// a word for every unmasked text or binary payload byte and for the last
// byte of each frame. On that last word rsp_tlast is high and the status,
// opcode and decoded payload length describe the frame; payload bytes given
// before an error status are to be dropped by the receiver.
// Each result word is registered and appears in the cycle after its byte
// is accepted. While no word is stalled one byte is accepted every cycle,
// as the single result register may be refilled in the cycle it is taken.
// Reset clears the parser state and the result valid flag; the first byte
// after reset or after a word with req_tlast is taken as a frame's first
// header byte. While the receiver holds rsp_tready low with a word waiting,
// req_tready is low and the input waits.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_byte [7:0], payload_length [71:8]
   output logic [8:0]  rsp_tuser,   // byte_valid [0], status [4:1], frame_opcode [8:5]
   output logic        rsp_tlast    // frame_done
);
   import wsd_pkg::*;

   logic       step;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (req_tdata),
      .frame_end (req_tlast),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (step) begin
         rsp_valid_in = result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.payload_length, rsp_ff.out_byte};
   assign rsp_tuser  = {rsp_ff.frame_opcode, rsp_ff.status, rsp_ff.byte_valid};
   assign rsp_tlast  = rsp_ff.frame_done;

endmodule

// ----- rtl/wsd_checker.sv -----
// Port checker for the WebSocket frame deframer, bound to the top level.
// Depends on wsd_pkg and the top level's port list.
module wsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [8:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import wsd_pkg::*;

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Every word carries a payload byte or ends a frame.
   a_rsp_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0] || rsp_tlast)
      else $error("result word with neither byte nor frame end");

   // Only text and binary frames give payload bytes.
   a_data_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tuser[8:5] == OP_TEXT)
         || (rsp_tuser[8:5] == OP_BINARY))
      else $error("payload byte from a non-data frame");

   // Status and length are reported only at the end of a frame.
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser[4:1] == ST_DATA) && (rsp_tdata[71:8] == 64'd0))
      else $error("status or length reported before the frame end");

   // An empty result register never holds the input back.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for websocket_frame_deframer: random and directed frames are
// streamed in, and every result word is compared with a built-in frame parser model.
// Depends on wsd_pkg and the deframer RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       hold;
   } frame_byte_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        valid;
      logic        done;
      status_type  status;
      logic [3:0]  opcode;
      logic [63:0] length;
   } deframe_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [8:0]  rsp_tuser;
   logic        rsp_tlast;

   frame_byte_type   frame_bytes_q[$];
   deframe_word_type decoded_words[$];
   logic             req_accepted = 1'b0;
   int               accepted_count = 0;
   int               stimulus_total = 0;
   int               cycle_count = 0;
   int               errors = 0;
   logic             calm;

   // Parser state of the model.
   logic [3:0]  hdr_count = '0;
   logic [3:0]  op_seen = '0;
   logic        masked = 1'b0;
   logic [6:0]  len_code = '0;
   logic [63:0] len_total = '0;
   logic [31:0] key = '0;
   logic [63:0] pay_count = '0;

   websocket_frame_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   assign calm = (cycle_count >= 700) && (cycle_count < 1100);

   function automatic int ext_len(input logic [6:0] code);
      if (code == LenCode16) return 2;
      if (code == LenCode64) return 8;
      return 0;
   endfunction

   function automatic string word_text(input deframe_word_type w);
      return $sformatf("byte %h valid %b done %b status %0d opcode %h length %h",
                       w.data, w.valid, w.done, w.status, w.opcode, w.length);
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic last);
      int               ext;
      int               hdr;
      logic             emit;
      logic [7:0]       plain;
      deframe_word_type w;
      ext = ext_len(len_code);
      hdr = 2 + ext + (masked ? 4 : 0);
      emit = 1'b0;
      plain = 8'h00;
      if (hdr_count == 4'd0) begin
         op_seen = b[3:0];
         hdr_count = 4'd1;
      end else if (hdr_count == 4'd1) begin
         masked = b[7];
         len_code = b[6:0];
         len_total = (b[6:0] < LenCode16) ? 64'(b[6:0]) : 64'd0;
         hdr_count = 4'd2;
      end else if (hdr_count < 2 + ext) begin
         len_total = {len_total[55:0], b};
         hdr_count = hdr_count + 4'd1;
      end else if (hdr_count < hdr) begin
         key = {key[23:0], b};
         hdr_count = hdr_count + 4'd1;
      end else if (pay_count < len_total) begin
         plain = b ^ (masked ? key[8 * (3 - pay_count[1:0]) +: 8] : 8'h00);
         emit = (op_seen == OP_TEXT) || (op_seen == OP_BINARY);
         pay_count = pay_count + 64'd1;
      end
      if (emit || last) begin
         w.data = emit ? plain : 8'h00;
         w.valid = emit;
         w.done = last;
         w.status = ST_DATA;
         w.opcode = op_seen;
         w.length = '0;
         if (last) begin
            ext = ext_len(len_code);
            hdr = 2 + ext + (masked ? 4 : 0);
            if (hdr_count < 2) w.status = ST_SHORT;
            else if (hdr_count < 2 + ext) w.status = ST_NO_EXTLEN;
            else if (hdr_count < hdr) w.status = ST_NO_KEY;
            else if (pay_count < len_total) w.status = ST_INCOMPLETE;
            else begin
               unique case (op_seen)
                  OP_TEXT, OP_BINARY: w.status = ST_DATA;
                  OP_CLOSE:           w.status = ST_CLOSE;
                  OP_PING:            w.status = ST_PING;
                  OP_PONG:            w.status = ST_PONG;
                  default:            w.status = ST_UNKNOWN;
               endcase
            end
            if (w.status != ST_SHORT && w.status != ST_NO_EXTLEN) w.length = len_total;
            hdr_count = '0;
            op_seen = '0;
            masked = 1'b0;
            len_code = '0;
            len_total = '0;
            key = '0;
            pay_count = '0;
         end
         decoded_words = {decoded_words, w};
      end
   endtask

   task automatic queue_random_frame(input logic hold);
      logic [7:0]     raw[$];
      logic [7:0]     first;
      logic           mask_on;
      logic [6:0]     code;
      logic [63:0]    len;
      frame_byte_type fb;
      int             pick;
      int             ext;
      int             body;
      int             keep;
      pick = $urandom_range(99);
      if (pick < 5) begin
         repeat ($urandom_range(1, 8)) raw = {raw, 8'($urandom)};
      end else begin
         first = 8'($urandom);
         pick = $urandom_range(99);
         if (pick < 60) first[3:0] = 4'($urandom_range(1, 2));
         else if (pick < 75) first[3:0] = 4'($urandom_range(8, 10));
         mask_on = 1'($urandom);
         pick = $urandom_range(99);
         if (pick < 4) code = 7'($urandom_range(13, 125));
         else if (pick < 70) code = 7'($urandom_range(12));
         else if (pick < 85) code = LenCode16;
         else code = LenCode64;
         if (code == LenCode16)
            len = ($urandom_range(9) == 0) ? 64'($urandom_range(65535))
                                           : 64'($urandom_range(16));
         else if (code == LenCode64)
            len = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(16));
         else
            len = 64'(code);
         ext = ext_len(code);
         raw = {raw, first};
         raw = {raw, {mask_on, code}};
         for (int i = ext - 1; i >= 0; i--) raw = {raw, len[8 * i +: 8]};
         if (mask_on) repeat (4) raw = {raw, 8'($urandom)};
         body = (len <= 64'd125) ? int'(len) : $urandom_range(6);
         repeat (body) raw = {raw, 8'($urandom)};
         pick = $urandom_range(99);
         keep = raw.size();
         if (pick >= 90) begin
            keep = $urandom_range(1, 2 + ext + (mask_on ? 4 : 0));
         end else if (pick >= 80) begin
            keep = $urandom_range(1, raw.size());
         end else if (pick >= 70) begin
            repeat ($urandom_range(1, 3)) raw = {raw, 8'($urandom)};
            keep = raw.size();
         end
         while (raw.size() > keep) void'(raw.pop_back());
      end
      foreach (raw[i]) begin
         fb.data = raw[i];
         fb.last = (i == raw.size() - 1);
         fb.hold = hold && (i == 0);
         frame_bytes_q = {frame_bytes_q, fb};
      end
   endtask

   // Directed frames: bit 8 marks the last byte of a frame.
   initial begin : stimulus
      logic [8:0]     directed[$];
      frame_byte_type fb;
      int             frame_index;
      directed = '{
         9'h181,                                              // one byte only
         9'h001, 9'h0FE, 9'h112,                              // extension cut off
         9'h002, 9'h085, 9'h0AA, 9'h1BB,                      // key cut off
         9'h082, 9'h082, 9'h012, 9'h034, 9'h056, 9'h078,
         9'h0FF, 9'h100,                                      // masked, ends on payload
         9'h088, 9'h000, 9'h177,                              // close with trailing byte
         9'h089, 9'h001, 9'h13C,                              // ping
         9'h08A, 9'h100,                                      // pong
         9'h0F3, 9'h100,                                      // unknown opcode
         9'h001, 9'h07E, 9'h0FF, 9'h0FF, 9'h100               // incomplete payload
      };
      foreach (directed[i]) begin
         fb.data = directed[i][7:0];
         fb.last = directed[i][8];
         fb.hold = 1'b0;
         frame_bytes_q = {frame_bytes_q, fb};
      end
      frame_index = 0;
      while (frame_bytes_q.size() < directed.size() + 900) begin
         queue_random_frame(frame_index == 0 || frame_index == 80);
         frame_index++;
      end
      stimulus_total = frame_bytes_q.size();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (accepted_count == stimulus_total);
      wait (decoded_words.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(negedge clock) begin : drive_ports
      frame_byte_type fb;
      logic           next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_accepted) begin
            next_valid = 1'b0;
            if (frame_bytes_q.size() > 0 &&
                !(frame_bytes_q[0].hold && decoded_words.size() != 0) &&
                (calm || $urandom_range(99) >= 26)) begin
               fb = frame_bytes_q.pop_front();
               req_tdata <= fb.data;
               req_tlast <= fb.last;
               next_valid = 1'b1;
            end
            req_tvalid <= next_valid;
         end
         rsp_tready <= calm || ($urandom_range(99) >= 26);
      end
   end

   always @(posedge clock) begin : watch_ports
      deframe_word_type got;
      deframe_word_type want;
      cycle_count <= cycle_count + 1;
      req_accepted <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.data = rsp_tdata[7:0];
            got.valid = rsp_tuser[0];
            got.done = rsp_tlast;
            got.status = status_type'(rsp_tuser[4:1]);
            got.opcode = rsp_tuser[8:5];
            got.length = rsp_tdata[71:8];
            if (decoded_words.size() == 0) begin
               $display("%0t: unexpected word, actual %s", $time, word_text(got));
               errors++;
            end else begin
               want = decoded_words.pop_front();
               if (got.data !== want.data || got.valid !== want.valid ||
                   got.done !== want.done || got.status !== want.status ||
                   got.opcode !== want.opcode || got.length !== want.length) begin
                  $display("%0t: mismatch, expected %s", $time, word_text(want));
                  $display("%0t:           actual   %s", $time, word_text(got));
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata, req_tlast);
            accepted_count++;
         end
      end
   end

endmodule

// ----- sim.f -----
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
rtl/wsd_checker.sv
sim/testbench.sv
